@@ rtl/core/section_translation_table_core_defines.svh @@
// assertion macros for the section translation table core
`ifndef SECTION_TRANSLATION_TABLE_CORE_DEFINES_SVH
`define SECTION_TRANSLATION_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk_i, off while in reset
`define STT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off while in reset
`define STT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/stt_pkg.sv @@
// types and constants of the section translation table core
package stt_pkg;

  localparam int unsigned STT_TABLE_ENTRIES = 4096;
  localparam int unsigned STT_TABLE_COUNT   = 2;

  // section index field of an address and the offset below it
  localparam int unsigned VPN_W    = 12;
  localparam int unsigned OFFSET_W = 20;

  localparam logic [31:0] BASE_MASK = 32'hFFF0_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  // descriptor type field
  localparam logic [1:0] TYPE_SECTION = 2'd2;

  // operation codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FWD   = 2'd1;
  localparam logic [1:0] FUNC_REV   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_SECTION = 2'd1;
  localparam logic [1:0] ST_FAULT       = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_FETCH,
    S_SCAN,
    S_RESP
  } state_e;

endpackage

@@ rtl/core/stt_req_if.sv @@
// request channel: one operation word per handshake
interface stt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        table_select;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [31:0] access_flags;

  modport source (
    output valid, func, table_select, virt_addr, phys_addr, access_flags,
    input  ready
  );

  modport sink (
    input  valid, func, table_select, virt_addr, phys_addr, access_flags,
    output ready
  );
endinterface

@@ rtl/core/stt_rsp_if.sv @@
// response channel: one result word per handshake
interface stt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_addr;

  modport source (
    output valid, status, result_addr,
    input  ready
  );

  modport sink (
    input  valid, status, result_addr,
    output ready
  );
endinterface

@@ rtl/core/section_translation_table_core.sv @@
// top level of the section translation table core
//
// usage
// - req_i carries one operation word: write a section descriptor, translate
//   virtual to physical (table 0 lookup) or physical to virtual (table 0 search)
// - rsp_o returns exactly one word per request: status and result address
// - cfg_we_i / cfg_wdata_i write mmu_enable; write it only while the core is idle
// - after reset the core clears its descriptor memory one entry per cycle,
//   all TABLE_COUNT * TABLE_ENTRIES entries (8192 by default); req_i.ready stays low
// - one request at a time: ready is high in the idle state only
// - writes, pass-through and unused codes go from the access state straight to
//   the response state, a forward lookup adds the fetch state (one memory read),
//   and a reverse search stays in the scan state until its first base match or
//   the last entry; the search walks table 0 one entry per cycle through the
//   single read port
// - the result sits in an output register; the next request is accepted while
//   it waits, and a stalled receiver only holds a finished result in the
//   response stage until the output register frees up
`include "section_translation_table_core_defines.svh"

module section_translation_table_core import stt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = STT_TABLE_ENTRIES,
  parameter int unsigned TABLE_COUNT   = STT_TABLE_COUNT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stt_req_if.sink       req_i,
  stt_rsp_if.source     rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  // memory geometry: table t, entry i lives at t * TABLE_ENTRIES + i
  localparam int unsigned Depth = TABLE_COUNT * TABLE_ENTRIES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = $clog2(TABLE_ENTRIES);

  // section index modulo TABLE_ENTRIES through a reciprocal multiply;
  // exact for 12-bit indices with this shift, no correction step needed
  localparam int unsigned RecipShift = 24;
  localparam int unsigned Recip      = ((1 << RecipShift) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
  localparam int unsigned RW         = $clog2(Recip + 1);
  localparam int unsigned PW         = VPN_W + RW;

  state_e            state_d, state_q;
  logic              mmu_enable_q;

  // captured request
  logic [1:0]        func_q;
  logic              sel_q;
  logic [31:0]       va_q;
  logic [31:0]       pa_q;
  logic [31:0]       flags_q;
  logic [VPN_W-1:0]  quot_d, quot_q;
  logic [PW-1:0]     quot_prod;

  // descriptor memory and its ports
  logic [31:0]       mem [Depth];
  logic [31:0]       rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [31:0]       mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // clearing pass and reverse search
  logic [AW-1:0]     clr_addr_q;
  logic [IW-1:0]     scan_addr_q;
  logic              scan_done_q;
  logic              cmp_valid_d, cmp_valid_q;
  logic [IW-1:0]     cmp_idx_q;
  logic              scan_match;
  logic              scan_last;

  // address and descriptor datapath
  logic [VPN_W-1:0]  vpn_mod;
  logic [IW-1:0]     entry_idx;
  logic              sel_eff;
  logic [AW-1:0]     tbl_base;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       new_desc;
  logic              flags_ok;

  // result and output register
  logic [1:0]        res_status_d, res_status_q;
  logic [31:0]       res_addr_d, res_addr_q;
  logic              load_out;
  logic              out_valid_d, out_valid_q;
  logic [1:0]        out_status_q;
  logic [31:0]       out_addr_q;

  // first step of the index reduction happens on the incoming word
  assign quot_prod = PW'(req_i.virt_addr[31:32-VPN_W]) * PW'(Recip);
  assign quot_d    = VPN_W'(quot_prod >> RecipShift);

  // second step: index minus quotient times table size
  assign vpn_mod   = va_q[31:32-VPN_W] - VPN_W'(quot_q * TABLE_ENTRIES);
  assign entry_idx = IW'(vpn_mod);

  // out-of-range table select falls back to table 0
  assign sel_eff   = (TABLE_COUNT > 1) ? sel_q : 1'b0;
  assign tbl_base  = sel_eff ? AW'(TABLE_ENTRIES) : '0;
  assign wr_addr   = tbl_base + AW'(entry_idx);

  // flags go in unmasked, so they may also set base bits
  assign new_desc  = (pa_q & BASE_MASK) | flags_q;
  assign flags_ok  = (flags_q[1:0] == TYPE_SECTION);

  assign scan_match = cmp_valid_q && (rdata_q[31:32-VPN_W] == pa_q[31:32-VPN_W]);
  assign scan_last  = cmp_valid_q && (cmp_idx_q == IW'(TABLE_ENTRIES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) state_d = S_ACCESS;
      end
      S_ACCESS: begin
        priority if (mmu_enable_q && func_q == FUNC_FWD) begin
          state_d = S_FETCH;
        end else if (mmu_enable_q && func_q == FUNC_REV) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FETCH: begin
        state_d = S_RESP;
      end
      S_SCAN: begin
        if (scan_match || scan_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state outputs: memory ports, request ready, output load
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = wr_addr;
    mem_wdata   = new_desc;
    rd_en       = 1'b0;
    rd_addr     = AW'(entry_idx);
    load_out    = 1'b0;
    req_i.ready = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
      end
      S_ACCESS: begin
        mem_we = (func_q == FUNC_WRITE) && flags_ok;
        rd_en  = (func_q == FUNC_FWD) && mmu_enable_q;
      end
      S_FETCH: begin
      end
      S_SCAN: begin
        rd_en   = !scan_done_q;
        rd_addr = AW'(scan_addr_q);
      end
      S_RESP: begin
        load_out = !out_valid_q || rsp_o.ready;
      end
      default: begin
      end
    endcase
  end

  // result of the current operation
  always_comb begin
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    unique case (state_q)
      S_ACCESS: begin
        res_status_d = ST_OK;
        res_addr_d   = '0;
        priority if (func_q == FUNC_WRITE) begin
          res_status_d = flags_ok ? ST_OK : ST_NOT_SECTION;
        end else if (func_q == FUNC_FWD) begin
          res_addr_d = va_q;
        end else if (func_q == FUNC_REV) begin
          res_addr_d = pa_q;
        end else begin
          res_addr_d = '0;
        end
      end
      S_FETCH: begin
        if (rdata_q[1:0] == TYPE_SECTION) begin
          res_status_d = ST_OK;
          res_addr_d   = {rdata_q[31:OFFSET_W], va_q[OFFSET_W-1:0]};
        end else begin
          res_status_d = ST_FAULT;
          res_addr_d   = ALL_ONES;
        end
      end
      S_SCAN: begin
        // first base match decides, section or not
        if (scan_match && rdata_q[1:0] == TYPE_SECTION) begin
          res_status_d = ST_OK;
          res_addr_d   = {VPN_W'(cmp_idx_q), pa_q[OFFSET_W-1:0]};
        end else begin
          res_status_d = ST_FAULT;
          res_addr_d   = ALL_ONES;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmp_valid_d = (state_q == S_SCAN) && rd_en;
  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  // descriptor memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      mmu_enable_q <= 1'b0;
      clr_addr_q   <= '0;
      scan_addr_q  <= '0;
      scan_done_q  <= 1'b0;
      cmp_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mmu_enable_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (state_q == S_ACCESS) begin
        scan_addr_q <= '0;
        scan_done_q <= 1'b0;
      end else if (state_q == S_SCAN && rd_en) begin
        scan_addr_q <= scan_addr_q + IW'(1);
        scan_done_q <= (scan_addr_q == IW'(TABLE_ENTRIES - 1));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= req_i.func;
      sel_q   <= req_i.table_select;
      va_q    <= req_i.virt_addr;
      pa_q    <= req_i.phys_addr;
      flags_q <= req_i.access_flags;
      quot_q  <= quot_d;
    end
    if (cmp_valid_d) begin
      cmp_idx_q <= scan_addr_q;
    end
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.result_addr = out_addr_q;

  // checks
  `STT_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !req_i.ready,
                  "request accepted during clearing pass")
  `STT_ASSERT_IMP(a_out_load_free, load_out, !out_valid_q || rsp_o.ready,
                  "result loaded over an untaken word")
  `STT_ASSERT_IMP(a_write_only_section, mem_we && state_q == S_ACCESS,
                  func_q == FUNC_WRITE && flags_q[1:0] == TYPE_SECTION,
                  "descriptor written without section flags")
  `STT_ASSERT_NXT(a_accept_to_access, req_i.valid && req_i.ready,
                  state_q == S_ACCESS, "accepted request did not reach access")

endmodule
